/* sv/srl_pkg.sv */
// Shared types and constants for the S-record loader.
// Used by srl_front, srl_queue, srl_back and srecord_s1_loader; no dependencies.
package srl_pkg;

    // Character codes the parser recognizes
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_FIVE    = 8'h35;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Hex digit decode: below ALPHA_BASE subtract DIGIT_OFFSET, else ALPHA_OFFSET
    localparam logic [7:0] ALPHA_BASE   = 8'h40;
    localparam logic [7:0] DIGIT_OFFSET = 8'h30;
    localparam logic [7:0] ALPHA_OFFSET = 8'h37;

    // Count byte covers two address bytes and the checksum
    localparam logic [7:0] HEADER_BYTES = 8'd3;

    localparam logic RESULT_WRITE = 1'b0;
    localparam logic RESULT_DONE  = 1'b1;

    // Queue between classifier and parser
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified character
    typedef struct packed {
        logic [3:0] digit;    // hex value, low 4 bits
        logic       is_s;     // record start
        logic       is_one;   // data record type
        logic       is_end;   // termination record type
    } token_t;

endpackage

/* sv/srl_front.sv */
// Front end of the S-record loader: takes characters and classifies them.
// Depends on srl_pkg; feeds srl_queue.
module srl_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       received_char,
    input  logic             q_full,
    output logic             q_push,
    output srl_pkg::token_t  q_token
);

    logic [7:0] diff;

    always_comb
    begin
        if (received_char < srl_pkg::ALPHA_BASE)
        begin
            diff = received_char - srl_pkg::DIGIT_OFFSET;
        end
        else
        begin
            diff = received_char - srl_pkg::ALPHA_OFFSET;
        end
        q_token.digit  = diff[3:0];
        q_token.is_s   = (received_char == srl_pkg::CHAR_S);
        q_token.is_one = (received_char == srl_pkg::CHAR_ONE);
        q_token.is_end = (received_char == srl_pkg::CHAR_FIVE) ||
                         (received_char == srl_pkg::CHAR_NINE);
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* sv/srl_queue.sv */
// Short token queue that decouples the classifier from the parser.
// Depends on srl_pkg.
module srl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  srl_pkg::token_t  push_token,
    output logic             full,
    input  logic             pop,
    output logic             tok_valid,
    output srl_pkg::token_t  tok
);

    srl_pkg::token_t                 mem [srl_pkg::QDEPTH];
    logic [srl_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [srl_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [srl_pkg::QCNT_W-1:0]      count_reg, count_next;

    localparam logic [srl_pkg::QPTR_W-1:0] PTR_LAST = srl_pkg::QPTR_W'(srl_pkg::QDEPTH - 1);
    localparam logic [srl_pkg::QCNT_W-1:0] CNT_FULL = srl_pkg::QCNT_W'(srl_pkg::QDEPTH);

    assign full      = (count_reg == CNT_FULL);
    assign tok_valid = (count_reg != '0);
    assign tok       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> tok_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

/* sv/srl_back.sv */
// Parser back end of the S-record loader: record state machine and result register.
// Depends on srl_pkg; consumes tokens from srl_queue.
module srl_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tok_valid,
    input  srl_pkg::token_t  tok,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             result_kind,
    output logic [15:0]      write_address,
    output logic [7:0]       write_data,
    output logic             checksum_failed
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_COUNT,
        PH_ADDR,
        PH_DATA,
        PH_CHECK
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   high_reg, high_next;
    logic         pending_reg, pending_next;
    logic         fpos_reg, fpos_next;
    logic [7:0]   remain_reg, remain_next;
    logic [15:0]  addr_reg, addr_next;
    logic [7:0]   offset_reg, offset_next;
    logic [7:0]   sum_reg, sum_next;
    logic         err_reg, err_next;

    logic         out_valid_reg, out_valid_next;
    logic         kind_reg, kind_next;
    logic [15:0]  waddr_reg, waddr_next;
    logic [7:0]   wdata_reg, wdata_next;
    logic         fail_reg, fail_next;

    logic [7:0]   byte_val;
    logic         produce;

    assign byte_val = {high_reg, tok.digit};
    assign produce  = ((phase_reg == PH_TYPE) && tok.is_end) ||
                      ((phase_reg == PH_DATA) && pending_reg);
    assign pop      = tok_valid && (!produce || !out_valid_reg || out_ready);

    always_comb
    begin
        phase_next     = phase_reg;
        high_next      = high_reg;
        pending_next   = pending_reg;
        fpos_next      = fpos_reg;
        remain_next    = remain_reg;
        addr_next      = addr_reg;
        offset_next    = offset_reg;
        sum_next       = sum_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        waddr_next     = waddr_reg;
        wdata_next     = wdata_reg;
        fail_next      = fail_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    phase_next = tok.is_s ? PH_TYPE : PH_WAIT;
                end
                PH_TYPE:
                begin
                    if (tok.is_one)
                    begin
                        phase_next   = PH_COUNT;
                        sum_next     = '0;
                        offset_next  = '0;
                        pending_next = 1'b0;
                        fpos_next    = 1'b0;
                        addr_next    = '0;
                    end
                    else if (tok.is_end)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = srl_pkg::RESULT_DONE;
                        waddr_next     = '0;
                        wdata_next     = '0;
                        fail_next      = err_reg;
                        err_next       = 1'b0;
                        phase_next     = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK:
                begin
                    if (!pending_reg)
                    begin
                        high_next    = tok.digit;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        pending_next = 1'b0;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                sum_next    = sum_reg + byte_val;
                                remain_next = (byte_val >= srl_pkg::HEADER_BYTES) ?
                                              byte_val - srl_pkg::HEADER_BYTES : '0;
                                fpos_next   = 1'b0;
                                phase_next  = PH_ADDR;
                            end
                            PH_ADDR:
                            begin
                                sum_next = sum_reg + byte_val;
                                if (!fpos_reg)
                                begin
                                    addr_next[15:8] = byte_val;
                                    fpos_next       = 1'b1;
                                end
                                else
                                begin
                                    addr_next[7:0] = byte_val;
                                    fpos_next      = 1'b0;
                                    phase_next     = (remain_reg != '0) ? PH_DATA : PH_CHECK;
                                end
                            end
                            PH_DATA:
                            begin
                                sum_next       = sum_reg + byte_val;
                                out_valid_next = 1'b1;
                                kind_next      = srl_pkg::RESULT_WRITE;
                                waddr_next     = addr_reg + {8'h00, offset_reg};
                                wdata_next     = byte_val;
                                fail_next      = 1'b0;
                                offset_next    = offset_reg + 8'd1;
                                remain_next    = remain_reg - 8'd1;
                                if (remain_reg == 8'd1)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            default:
                            begin
                                // checksum byte: one's complement of the running sum
                                if (~sum_reg != byte_val)
                                begin
                                    err_next = 1'b1;
                                end
                                phase_next = PH_WAIT;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // unused codes act as waiting for 'S'
                    phase_next = tok.is_s ? PH_TYPE : PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            high_reg      <= '0;
            pending_reg   <= 1'b0;
            fpos_reg      <= 1'b0;
            remain_reg    <= '0;
            addr_reg      <= '0;
            offset_reg    <= '0;
            sum_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            waddr_reg     <= '0;
            wdata_reg     <= '0;
            fail_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            high_reg      <= high_next;
            pending_reg   <= pending_next;
            fpos_reg      <= fpos_next;
            remain_reg    <= remain_next;
            addr_reg      <= addr_next;
            offset_reg    <= offset_next;
            sum_reg       <= sum_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            waddr_reg     <= waddr_next;
            wdata_reg     <= wdata_next;
            fail_reg      <= fail_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign write_address   = waddr_reg;
    assign write_data      = wdata_reg;
    assign checksum_failed = fail_reg;

    a_data_emits_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (phase_reg == PH_DATA) && pending_reg) |=>
            (out_valid_reg && (kind_reg == srl_pkg::RESULT_WRITE)))
        else $error("data byte did not produce a write item");

    a_done_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (phase_reg == PH_TYPE) && tok.is_end) |=>
            (!err_reg && out_valid_reg && (kind_reg == srl_pkg::RESULT_DONE)))
        else $error("finish item did not clear the error flag");

    a_fpos_in_addr: assert property (@(posedge clk) disable iff (!rst_n)
        fpos_reg |-> (phase_reg == PH_ADDR))
        else $error("address byte position set outside address field");

endmodule

/* sv/srecord_s1_loader.sv */
// Top level of the S-record loader: classifier, token queue and parser.
// Depends on srl_pkg, srl_front, srl_queue and srl_back.
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_ready, received_char               | in
//  output   | out_valid, out_ready, result_kind,              | out
//           | write_address, write_data, checksum_failed      |
//
// One character per cycle sustained, unless an output stall lets the queue fill.
// A result is registered at the edge its character leaves the two-entry queue,
// so a character passes a queue entry and then the result register before out_valid rises.
// Asynchronous active-low reset returns the parser to waiting for 'S'.
// An output stall holds only characters that make a result; the queue keeps
// accepting until it fills.
module srecord_s1_loader (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  received_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [15:0] write_address,
    output logic [7:0]  write_data,
    output logic        checksum_failed
);

    logic             q_full;
    logic             q_push;
    srl_pkg::token_t  q_in_token;
    logic             q_pop;
    logic             q_valid;
    srl_pkg::token_t  q_out_token;

    srl_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .received_char (received_char),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_token       (q_in_token)
    );

    srl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (q_in_token),
        .full       (q_full),
        .pop        (q_pop),
        .tok_valid  (q_valid),
        .tok        (q_out_token)
    );

    srl_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .tok_valid       (q_valid),
        .tok             (q_out_token),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .write_address   (write_address),
        .write_data      (write_data),
        .checksum_failed (checksum_failed)
    );

endmodule
